/* hw/rtl/bfg_pkg.sv */
// constants, register indexes and the cell voltage table for the fuel gauge
// no dependencies
package bfg_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_SERIES     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARALLEL   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_USABLE     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESISTANCE = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WARN       = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF     = 4'd7;

    localparam logic [21:0] AH_SCALE      = 22'd3515625;
    // ceil(2^43 / 3515625) + 1, charge in units of 1024 nC to whole mAh
    localparam logic [21:0] MAH_RECIP     = 22'd2502001;
    localparam logic [19:0] UOHM_PER_OHM  = 20'd1000000;
    localparam logic [16:0] Q16_ONE       = 17'd65536;
    localparam logic [16:0] SCALE_EMPTY   = 17'd104858;
    localparam logic [19:0] SEG_KNEE      = 20'd196608;
    localparam logic [12:0] OCV_FULL_MV   = 13'd4200;
    localparam logic [18:0] MAH_MAX       = 19'h7FFFF;

    typedef logic [12:0] mv_t;

    function automatic mv_t ocv_mv(input logic [3:0] idx);
        mv_t v;
        case (idx)
            4'd0:    v = 13'd3000;
            4'd1:    v = 13'd3400;
            4'd2:    v = 13'd3550;
            4'd3:    v = 13'd3650;
            4'd4:    v = 13'd3700;
            4'd5:    v = 13'd3750;
            4'd6:    v = 13'd3800;
            4'd7:    v = 13'd3870;
            4'd8:    v = 13'd3950;
            4'd9:    v = 13'd4080;
            default: v = 13'd4200;
        endcase
        return v;
    endfunction

    function automatic logic [8:0] ocv_step_mv(input logic [3:0] idx);
        mv_t d;
        d = ocv_mv(idx + 4'd1) - ocv_mv(idx);
        return d[8:0];
    endfunction

endpackage

/* hw/rtl/battery_fuel_gauge_model_unit.sv */
// coulomb counting fuel gauge top level with one shared shift-add/subtract unit
// depends on bfg_pkg
//
// channel   direction  handshake             payload
// input     in         in_valid / in_ready   current_ma, tick_us
// result    out        out_valid / out_ready soc_q16 .. cutoff_active
// config    in         cfg_write_en          cfg_index, cfg_data
//
// one request runs seventeen operations in turn on the shared 64-bit adder, one
// operand bit a cycle; the long divisions for state of charge (68 bits) and sag (43)
// dominate
// in_ready is high only while idle; a finished result waits in the output register
// reset clears the accumulator and loads the register defaults
module battery_fuel_gauge_model_unit
    import bfg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [18:0]    current_ma,
    input  logic [19:0]           tick_us,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [16:0]           soc_q16,
    output logic [18:0]           consumed_mah,
    output logic [15:0]           pack_ocv_mv,
    output logic [15:0]           pack_loaded_mv,
    output logic [12:0]           cell_loaded_mv,
    output logic [16:0]           resistance_scale_q16,
    output logic [16:0]           output_scale_q16,
    output logic                  low_voltage_warn,
    output logic                  critical_voltage,
    output logic                  cutoff_active,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_U1   = 5'd1;
    localparam logic [4:0] ST_U2   = 5'd2;
    localparam logic [4:0] ST_U3   = 5'd3;
    localparam logic [4:0] ST_CHG  = 5'd4;
    localparam logic [4:0] ST_SOC  = 5'd5;
    localparam logic [4:0] ST_MAH  = 5'd6;
    localparam logic [4:0] ST_MCHK = 5'd7;
    localparam logic [4:0] ST_OCV  = 5'd8;
    localparam logic [4:0] ST_PACK = 5'd9;
    localparam logic [4:0] ST_PDIV = 5'd10;
    localparam logic [4:0] ST_G1   = 5'd11;
    localparam logic [4:0] ST_G2   = 5'd12;
    localparam logic [4:0] ST_G3   = 5'd13;
    localparam logic [4:0] ST_SAG  = 5'd14;
    localparam logic [4:0] ST_FLR  = 5'd15;
    localparam logic [4:0] ST_CELL = 5'd16;
    localparam logic [4:0] ST_OUT  = 5'd17;
    localparam logic [4:0] ST_FIN  = 5'd18;

    // configuration
    logic [3:0]  series_reg, parallel_reg;
    logic [15:0] capacity_reg;
    logic [16:0] usable_frac_reg;
    logic [19:0] resistance_reg;
    logic [12:0] warn_reg, critical_reg, cutoff_reg;

    // control
    logic [4:0]  state_reg, state_next;
    logic        run_reg, run_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic [51:0] consumed_reg, consumed_next;

    // shared unit
    logic [63:0] x_reg, x_next, acc_reg, acc_next;
    logic [71:0] y_reg, y_next;
    logic        div_mode;
    logic [63:0] rs, op_a, op_b;
    logic [64:0] sum;

    // intermediate results
    logic [17:0] cur_reg, cur_next;
    logic [19:0] tick_reg, tick_next;
    logic [51:0] usable_reg, usable_next;
    logic [16:0] soc_reg, soc_next;
    logic [19:0] est_reg, est_next;
    logic [18:0] mah_reg, mah_next;
    logic [12:0] cell_ocv_reg, cell_ocv_next;
    logic [15:0] pack_ocv_reg, pack_ocv_next;
    logic [16:0] scale_reg, scale_next;
    logic [23:0] den_reg, den_next;
    logic [23:0] sag_reg, sag_next;
    logic [16:0] loaded_reg, loaded_next;
    logic [16:0] cell_reg, cell_next;
    logic [16:0] outscale_reg, outscale_next;
    logic        load_out;

    logic [19:0] seg;
    logic [3:0]  seg_idx;
    logic [16:0] frac_sat;
    logic [3:0]  pdiv;
    logic [15:0] sagged;
    logic [16:0] floor_mv;
    logic [12:0] span_mv;
    logic [12:0] over_mv;
    logic [16:0] soc_q;
    logic [19:0] mah_q;

    assign frac_sat = usable_frac_reg[16] ? Q16_ONE : usable_frac_reg;
    assign pdiv     = (parallel_reg == 4'd0) ? 4'd1 : parallel_reg;
    assign seg      = ({3'b0, soc_reg} << 3) + ({3'b0, soc_reg} << 1);
    assign seg_idx  = seg[19:16];
    assign span_mv  = critical_reg - cutoff_reg;
    assign over_mv  = cell_reg[12:0] - cutoff_reg;
    assign floor_mv = acc_reg[16:0];
    assign sagged   = pack_ocv_reg - sag_reg[15:0];
    assign soc_q    = y_reg[16:0];
    // reciprocal estimate is exact or one too high
    assign mah_q    = (acc_reg > {22'b0, consumed_reg[51:10]}) ? est_reg - 20'd1 : est_reg;

    assign div_mode = (state_reg == ST_SOC) || (state_reg == ST_SAG) ||
                      (state_reg == ST_CELL) || (state_reg == ST_OUT);
    assign rs   = {acc_reg[62:0], y_reg[71]};
    assign op_a = div_mode ? rs : acc_reg;
    assign op_b = div_mode ? ~x_reg : x_reg;
    assign sum  = {1'b0, op_a} + {1'b0, op_b} + {64'b0, div_mode};

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        run_next       = run_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        acc_next       = acc_reg;
        consumed_next  = consumed_reg;
        cur_next       = cur_reg;
        tick_next      = tick_reg;
        usable_next    = usable_reg;
        soc_next       = soc_reg;
        est_next       = est_reg;
        mah_next       = mah_reg;
        cell_ocv_next  = cell_ocv_reg;
        pack_ocv_next  = pack_ocv_reg;
        scale_next     = scale_reg;
        den_next       = den_reg;
        sag_next       = sag_reg;
        loaded_next    = loaded_reg;
        cell_next      = cell_reg;
        outscale_next  = outscale_reg;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        if (state_reg == ST_IDLE)
        begin
            if (in_valid)
            begin
                cur_next   = current_ma[18] ? 18'd0 : current_ma[17:0];
                tick_next  = tick_us;
                state_next = ST_U1;
                run_next   = 1'b0;
            end
        end
        else if (state_reg == ST_FIN)
        begin
            if (!out_valid_reg || out_ready)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
        end
        else if (run_reg && cnt_reg != 7'd0)
        begin
            // one bit of multiply or divide
            cnt_next = cnt_reg - 7'd1;
            if (div_mode)
            begin
                acc_next = sum[64] ? sum[63:0] : rs;
                y_next   = {y_reg[70:0], sum[64]};
            end
            else
            begin
                if (y_reg[0])
                    acc_next = sum[63:0];
                x_next = {x_reg[62:0], 1'b0};
                y_next = {1'b0, y_reg[71:1]};
            end
        end
        else if (run_reg)
        begin
            // capture result
            run_next   = 1'b0;
            state_next = state_reg + 5'd1;
            unique case (state_reg)
                ST_U3:   usable_next = acc_reg[57:6];
                ST_CHG:  consumed_next = (acc_reg > {12'b0, usable_reg}) ?
                                         usable_reg : acc_reg[51:0];
                ST_SOC:  soc_next = Q16_ONE - soc_q - {16'b0, (acc_reg != 64'd0)};
                ST_MAH:  est_next = acc_reg[62:43];
                ST_MCHK: mah_next = mah_q[19] ? MAH_MAX : mah_q[18:0];
                ST_OCV:  cell_ocv_next = ocv_mv(seg_idx) + {4'b0, acc_reg[24:16]};
                ST_PACK: pack_ocv_next = acc_reg[15:0];
                ST_PDIV: den_next = acc_reg[23:0];
                ST_SAG:  sag_next = y_reg[23:0];
                ST_FLR:
                begin
                    if ((sag_reg > {8'b0, pack_ocv_reg}) || ({1'b0, sagged} < floor_mv))
                        loaded_next = floor_mv;
                    else
                        loaded_next = {1'b0, sagged};
                end
                ST_CELL: cell_next = y_reg[16:0];
                ST_OUT:  outscale_next = y_reg[16:0];
                default: ;
            endcase
        end
        else
        begin
            // operand setup
            run_next = 1'b1;
            acc_next = 64'd0;
            unique case (state_reg)
                ST_U1:
                begin
                    x_next   = {48'b0, capacity_reg};
                    y_next   = {68'b0, parallel_reg};
                    cnt_next = 7'd4;
                end
                ST_U2:
                begin
                    x_next   = acc_reg;
                    y_next   = {55'b0, frac_sat};
                    cnt_next = 7'd17;
                end
                ST_U3:
                begin
                    x_next   = acc_reg;
                    y_next   = {50'b0, AH_SCALE};
                    cnt_next = 7'd22;
                end
                ST_CHG:
                begin
                    acc_next = {12'b0, consumed_reg};
                    x_next   = {46'b0, cur_reg};
                    y_next   = {52'b0, tick_reg};
                    cnt_next = 7'd20;
                end
                ST_SOC:
                begin
                    if (usable_reg == 52'd0)
                    begin
                        soc_next   = Q16_ONE;
                        run_next   = 1'b0;
                        state_next = ST_MAH;
                    end
                    x_next   = {12'b0, usable_reg};
                    y_next   = {consumed_reg, 20'b0};
                    cnt_next = 7'd68;
                end
                ST_MAH:
                begin
                    x_next   = {22'b0, consumed_reg[51:10]};
                    y_next   = {50'b0, MAH_RECIP};
                    cnt_next = 7'd22;
                end
                ST_MCHK:
                begin
                    x_next   = {42'b0, AH_SCALE};
                    y_next   = {52'b0, est_reg};
                    cnt_next = 7'd20;
                end
                ST_OCV:
                begin
                    scale_next = (seg >= SEG_KNEE) ? Q16_ONE :
                                 SCALE_EMPTY - {soc_reg[15:0], 1'b0};
                    if (seg_idx >= 4'd10)
                    begin
                        cell_ocv_next = OCV_FULL_MV;
                        run_next      = 1'b0;
                        state_next    = ST_PACK;
                    end
                    x_next   = {55'b0, ocv_step_mv(seg_idx)};
                    y_next   = {56'b0, seg[15:0]};
                    cnt_next = 7'd16;
                end
                ST_PACK:
                begin
                    x_next   = {51'b0, cell_ocv_reg};
                    y_next   = {68'b0, series_reg};
                    cnt_next = 7'd4;
                end
                ST_PDIV:
                begin
                    x_next   = {44'b0, UOHM_PER_OHM};
                    y_next   = {68'b0, pdiv};
                    cnt_next = 7'd4;
                end
                ST_G1:
                begin
                    x_next   = {46'b0, cur_reg};
                    y_next   = {68'b0, series_reg};
                    cnt_next = 7'd4;
                end
                ST_G2:
                begin
                    x_next   = acc_reg;
                    y_next   = {52'b0, resistance_reg};
                    cnt_next = 7'd20;
                end
                ST_G3:
                begin
                    x_next   = acc_reg;
                    y_next   = {55'b0, scale_reg};
                    cnt_next = 7'd17;
                end
                ST_SAG:
                begin
                    x_next   = {40'b0, den_reg};
                    y_next   = {acc_reg[58:16], 29'b0};
                    cnt_next = 7'd43;
                end
                ST_FLR:
                begin
                    x_next   = {51'b0, cutoff_reg};
                    y_next   = {68'b0, series_reg};
                    cnt_next = 7'd4;
                end
                ST_CELL:
                begin
                    if (series_reg == 4'd0)
                    begin
                        cell_next  = 17'd0;
                        run_next   = 1'b0;
                        state_next = ST_OUT;
                    end
                    x_next   = {60'b0, series_reg};
                    y_next   = {loaded_reg, 55'b0};
                    cnt_next = 7'd17;
                end
                ST_OUT:
                begin
                    if (cell_reg <= {4'b0, cutoff_reg})
                    begin
                        outscale_next = 17'd0;
                        run_next      = 1'b0;
                        state_next    = ST_FIN;
                    end
                    else if (cell_reg >= {4'b0, critical_reg})
                    begin
                        outscale_next = Q16_ONE;
                        run_next      = 1'b0;
                        state_next    = ST_FIN;
                    end
                    x_next   = {51'b0, span_mv};
                    y_next   = {over_mv, 59'b0};
                    cnt_next = 7'd29;
                end
                default: run_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_reg       <= 1'b0;
            cnt_reg       <= 7'd0;
            out_valid_reg <= 1'b0;
            consumed_reg  <= 52'd0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            consumed_reg  <= consumed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            series_reg      <= 4'd6;
            parallel_reg    <= 4'd1;
            capacity_reg    <= 16'd1500;
            usable_frac_reg <= 17'd52429;
            resistance_reg  <= 20'd20000;
            warn_reg        <= 13'd3500;
            critical_reg    <= 13'd3300;
            cutoff_reg      <= 13'd3000;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_SERIES:     series_reg      <= cfg_data[3:0];
                REG_PARALLEL:   parallel_reg    <= cfg_data[3:0];
                REG_CAPACITY:   capacity_reg    <= cfg_data[15:0];
                REG_USABLE:     usable_frac_reg <= cfg_data[16:0];
                REG_RESISTANCE: resistance_reg  <= cfg_data;
                REG_WARN:       warn_reg        <= cfg_data[12:0];
                REG_CRITICAL:   critical_reg    <= cfg_data[12:0];
                REG_CUTOFF:     cutoff_reg      <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        acc_reg      <= acc_next;
        cur_reg      <= cur_next;
        tick_reg     <= tick_next;
        usable_reg   <= usable_next;
        soc_reg      <= soc_next;
        est_reg      <= est_next;
        mah_reg      <= mah_next;
        cell_ocv_reg <= cell_ocv_next;
        pack_ocv_reg <= pack_ocv_next;
        scale_reg    <= scale_next;
        den_reg      <= den_next;
        sag_reg      <= sag_next;
        loaded_reg   <= loaded_next;
        cell_reg     <= cell_next;
        outscale_reg <= outscale_next;
        if (load_out)
        begin
            soc_q16              <= soc_reg;
            consumed_mah         <= mah_reg;
            pack_ocv_mv          <= pack_ocv_reg;
            pack_loaded_mv       <= loaded_reg[16] ? 16'hFFFF : loaded_reg[15:0];
            cell_loaded_mv       <= cell_reg[12:0];
            resistance_scale_q16 <= scale_reg;
            output_scale_q16     <= outscale_reg;
            low_voltage_warn     <= (cell_reg <= {4'b0, warn_reg});
            critical_voltage     <= (cell_reg <= {4'b0, critical_reg});
            cutoff_active        <= (cell_reg <= {4'b0, cutoff_reg});
        end
    end

    // checks on the sequencer and result ranges
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while a request is in progress");

    a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (soc_q16 <= Q16_ONE))
        else $error("state of charge above full");

    a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (resistance_scale_q16 >= Q16_ONE &&
                       resistance_scale_q16 <= SCALE_EMPTY))
        else $error("resistance scale out of range");

    a_cutoff_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cutoff_active) |-> (output_scale_q16 == 17'd0))
        else $error("output scale non-zero at cutoff");

endmodule

/* test/testbench.sv */
// self-checking testbench for battery_fuel_gauge_model_unit: directed corners, random register
// settings, randomised requests with idling and back-pressure, checked by a local predictor
// depends on bfg_pkg and battery_fuel_gauge_model_unit
module testbench;
    import bfg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd12;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP = 4'd15;
    localparam int STALL_LIMIT = 8000;
    localparam int SETTLE_CYCLES = 450;

    typedef struct {
        logic [16:0] soc;
        logic [18:0] mah;
        logic [15:0] pack_ocv;
        logic [15:0] pack_loaded;
        logic [12:0] cell_mv;
        logic [16:0] rscale;
        logic [16:0] oscale;
        logic        warn;
        logic        crit;
        logic        cut;
    } gauge_reading_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [18:0] current_ma = '0;
    logic [19:0] tick_us = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [16:0] soc_q16;
    logic [18:0] consumed_mah;
    logic [15:0] pack_ocv_mv;
    logic [15:0] pack_loaded_mv;
    logic [12:0] cell_loaded_mv;
    logic [16:0] resistance_scale_q16;
    logic [16:0] output_scale_q16;
    logic low_voltage_warn;
    logic critical_voltage;
    logic cutoff_active;
    logic cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // register mirror and charge accumulator
    logic [3:0]  series_r = 4'd6;
    logic [3:0]  parallel_r = 4'd1;
    logic [15:0] capacity_r = 16'd1500;
    logic [16:0] usable_r = 17'd52429;
    logic [19:0] resist_r = 20'd20000;
    logic [12:0] warn_r = 13'd3500;
    logic [12:0] crit_r = 13'd3300;
    logic [12:0] cutoff_r = 13'd3000;
    logic [127:0] drawn_nc = '0;

    gauge_reading_t pending_readings[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    int cell_table_mv[11] = '{3000, 3400, 3550, 3650, 3700, 3750, 3800, 3870, 3950, 4080, 4200};

    battery_fuel_gauge_model_unit dut (.*);

    always #6 clk = ~clk;

    function automatic gauge_reading_t gauge_predict(input logic signed [18:0] cur_in,
                                                     input logic [19:0] tick);
        gauge_reading_t r;
        logic [127:0] cur, frac, usable, soc, mah, seg, idx, alpha, ocv, pack, scale;
        logic [127:0] pdiv, sag, floor_mv, loaded, cell_mv, oscale;
        cur = cur_in[18] ? 128'd0 : 128'(cur_in[17:0]);
        frac = usable_r > 17'd65536 ? 128'd65536 : 128'(usable_r);
        usable = (128'(parallel_r) * capacity_r * frac * 128'd3515625) >> 6;
        drawn_nc = drawn_nc + cur * tick;
        if (drawn_nc > usable)
            drawn_nc = usable;
        soc = usable == 0 ? 128'd65536 : ((usable - drawn_nc) << 16) / usable;
        mah = drawn_nc / 128'd3600000000;
        if (mah > 128'h7FFFF)
            mah = 128'h7FFFF;
        seg = soc * 10;
        idx = seg >> 16;
        alpha = seg & 128'hFFFF;
        if (idx >= 10)
            ocv = 128'd4200;
        else
            ocv = cell_table_mv[idx] +
                  ((128'(cell_table_mv[idx + 1] - cell_table_mv[idx]) * alpha) >> 16);
        pack = ocv * series_r;
        scale = seg >= 128'd196608 ? 128'd65536 : 128'd104858 - 2 * soc;
        pdiv = parallel_r == 0 ? 128'd1 : 128'(parallel_r);
        sag = (cur * series_r * resist_r * scale) / (pdiv * 128'd65536 * 128'd1000000);
        floor_mv = 128'(series_r) * cutoff_r;
        loaded = (pack < floor_mv + sag) ? floor_mv : pack - sag;
        cell_mv = series_r == 0 ? 128'd0 : loaded / series_r;
        if (cell_mv <= cutoff_r)
            oscale = 0;
        else if (cell_mv >= crit_r)
            oscale = 128'd65536;
        else
            oscale = ((cell_mv - cutoff_r) * 65536) / (crit_r - cutoff_r);
        r.soc = soc[16:0];
        r.mah = mah[18:0];
        r.pack_ocv = pack[15:0];
        r.pack_loaded = loaded > 128'hFFFF ? 16'hFFFF : loaded[15:0];
        r.cell_mv = cell_mv[12:0];
        r.rscale = scale[16:0];
        r.oscale = oscale[16:0];
        r.warn = cell_mv <= warn_r;
        r.crit = cell_mv <= crit_r;
        r.cut = cell_mv <= cutoff_r;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", field, got, want);
        errors++;
    endtask

    task automatic check_field(input string field, input longint got, input longint want);
        if (got != want)
            report_mismatch(field, got, want);
    endtask

    // result checker
    always @(posedge clk) begin
        gauge_reading_t e;
        if (rst_n && out_valid && out_ready) begin
            if (pending_readings.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else begin
                e = pending_readings.pop_front();
                check_field("soc_q16", soc_q16, e.soc);
                check_field("consumed_mah", consumed_mah, e.mah);
                check_field("pack_ocv_mv", pack_ocv_mv, e.pack_ocv);
                check_field("pack_loaded_mv", pack_loaded_mv, e.pack_loaded);
                check_field("cell_loaded_mv", cell_loaded_mv, e.cell_mv);
                check_field("resistance_scale_q16", resistance_scale_q16, e.rscale);
                check_field("output_scale_q16", output_scale_q16, e.oscale);
                check_field("low_voltage_warn", low_voltage_warn, e.warn);
                check_field("critical_voltage", critical_voltage, e.crit);
                check_field("cutoff_active", cutoff_active, e.cut);
            end
        end
    end

    // receiver stalls and long hold-off
    always @(negedge clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic send_request(input logic signed [18:0] cur, input logic [19:0] tick);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        current_ma <= cur;
        tick_us <= tick;
        do @(posedge clk); while (!in_ready);
        pending_readings.push_back(gauge_predict(cur, tick));
        @(negedge clk);
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (pending_readings.size() != 0)
            @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            REG_SERIES:     series_r = v[3:0];
            REG_PARALLEL:   parallel_r = v[3:0];
            REG_CAPACITY:   capacity_r = v[15:0];
            REG_USABLE:     usable_r = v[16:0];
            REG_RESISTANCE: resist_r = v[19:0];
            REG_WARN:       warn_r = v[12:0];
            REG_CRITICAL:   crit_r = v[12:0];
            REG_CUTOFF:     cutoff_r = v[12:0];
            default:        ;
        endcase
        @(negedge clk);
    endtask

    task automatic configure(input int s, input int p, input int cap, input int frac,
                             input int res, input int warn, input int crit, input int cut);
        write_reg(REG_SERIES, CFG_DATA_W'(s));
        write_reg(REG_PARALLEL, CFG_DATA_W'(p));
        write_reg(REG_CAPACITY, CFG_DATA_W'(cap));
        write_reg(REG_USABLE, CFG_DATA_W'(frac));
        write_reg(REG_RESISTANCE, CFG_DATA_W'(res));
        write_reg(REG_WARN, CFG_DATA_W'(warn));
        write_reg(REG_CRITICAL, CFG_DATA_W'(crit));
        write_reg(REG_CUTOFF, CFG_DATA_W'(cut));
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    // zero capacity clamps the accumulator back to empty
    task automatic refill_pack();
        write_reg(REG_PARALLEL, 20'd0);
        cfg_write_en <= 1'b0;
        @(negedge clk);
        send_request(19'sd1000, 20'd1000);
        wait_idle();
    endtask

    task automatic test_defaults();
        send_request(19'sd0, 20'd0);
        send_request(-19'sd262144, 20'd1000000);
        send_request(-19'sd1, 20'hFFFFF);
        send_request(19'sd1, 20'd1);
        // drain the pack to empty and past it
        repeat (18) send_request(19'sd262143, 20'd1000000);
        wait_idle();
    endtask

    task automatic test_corners();
        refill_pack();
        configure(12, 8, 65535, 65536, 1000000, 4500, 4500, 4500);
        send_request(19'sd262143, 20'd1000000);
        send_request(19'sd262143, 20'hFFFFF);
        wait_idle();
        configure(0, 0, 0, 0, 0, 0, 0, 0);
        send_request(19'sd262143, 20'd1000000);
        wait_idle();
        // no series cells, usable fraction above one
        configure(0, 2, 1000, 131071, 50000, 3500, 3300, 3000);
        send_request(19'sd20000, 20'd500000);
        wait_idle();
        // critical below cutoff, unknown index ignored
        configure(4, 0, 2000, 65536, 900000, 3600, 2900, 3100);
        write_reg(REG_UNUSED, 20'hFFFFF);
        write_reg(REG_INDEX_TOP, 20'd0);
        cfg_write_en <= 1'b0;
        @(negedge clk);
        send_request(19'sd5000, 20'd1000);
        send_request(19'sd262143, 20'd1000000);
        wait_idle();
        // floor above the pack voltage field
        configure(12, 1, 3000, 65536, 20000, 8191, 8191, 8191);
        send_request(19'sd100, 20'd100);
        wait_idle();
    endtask

    task automatic random_phase(input int items);
        int cut, crit, warn;
        logic signed [18:0] cur;
        logic [19:0] tick;
        refill_pack();
        cut = $urandom_range(2500, 3400);
        crit = cut + $urandom_range(0, 500);
        warn = crit + $urandom_range(0, 500);
        if ($urandom_range(0, 9) == 0)
            crit = $urandom_range(0, 4500);
        configure($urandom_range(0, 20) == 0 ? 0 : $urandom_range(1, 12),
                  $urandom_range(1, 8), $urandom_range(1, 3000),
                  $urandom_range(0, 9) == 0 ? $urandom_range(0, 131071) :
                                               $urandom_range(20000, 65536),
                  $urandom_range(0, 1000000), warn, crit, cut);
        repeat (items) begin
            case ($urandom_range(0, 9))
                0:       cur = -19'sd262144 + 19'($urandom_range(0, 262143));
                1:       cur = 19'($urandom_range(0, 100));
                default: cur = 19'($urandom_range(0, 262143));
            endcase
            tick = $urandom_range(0, 9) == 0 ? 20'($urandom) : 20'($urandom_range(0, 1000000));
            send_request(cur, tick);
        end
        wait_idle();
    endtask

    task automatic test_random();
        int idle_send[4] = '{0, 48, 0, 33};
        int idle_recv[4] = '{0, 0, 48, 33};
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_send[ph];
            recv_stall_pct = idle_recv[ph];
            random_phase(130);
            random_phase(130);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_request = 3000;
        repeat (6) send_request(19'($urandom_range(0, 262143)), 20'($urandom_range(0, 1000000)));
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_defaults();
        test_corners();
        test_random();
        test_backpressure();
        if (errors == 0 && pending_readings.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

/* battery_fuel_gauge_model_unit.f */
hw/rtl/bfg_pkg.sv
hw/rtl/battery_fuel_gauge_model_unit.sv
test/testbench.sv
